/* hdl/jtok_pkg.sv */
// ----------------------------------------------------------------------------
// jtok_pkg: shared types for the JSON tokenizer
// Result kinds, token types, the result item and the per-item result bundle
// that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package jtok_pkg;

	localparam int MAX_RESULTS = 3;

	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERROR = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		TYPE_BARE  = 2'd0,
		TYPE_STR   = 2'd1,
		TYPE_PUNCT = 2'd2
	} ttype_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] code;
		ttype_t      ttype;
	} result_t;

	// count is the number of valid entries in res, starting at res[0].
	typedef struct packed {
		logic [1:0]                     count;
		result_t [MAX_RESULTS-1:0]      res;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic result_t mk_result(kind_t kind, logic [15:0] code, ttype_t ttype);
		result_t r;
		r.kind  = kind;
		r.code  = code;
		r.ttype = ttype;
		return r;
	endfunction

endpackage

/* hdl/jtok_front.sv */
// ----------------------------------------------------------------------------
// jtok_front: lexer front end
// Accepts text bytes, advances the lexer state and builds the bundle of
// results that each byte causes, pushing it into the result queue.
// ----------------------------------------------------------------------------
module jtok_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         text_byte,
	input  logic               end_of_text,
	input  logic               text_valid,
	output logic               text_stall,
	input  jtok_pkg::qstat_t   qstat,
	output logic               push,
	output jtok_pkg::bundle_t  push_data
);

	typedef enum logic [5:0] {
		M_IDLE = 6'b000001,
		M_BARE = 6'b000010,
		M_STR  = 6'b000100,
		M_ESC  = 6'b001000,
		M_HEX  = 6'b010000,
		M_ERR  = 6'b100000
	} mode_t;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;

	mode_t             mode_q, mode_d;
	logic [1:0]        hex_cnt_q, hex_cnt_d;
	logic [15:0]       acc_q, acc_d;
	jtok_pkg::bundle_t bnd;
	logic              accept;
	logic              is_punct, is_space, is_digit, is_uhex;
	logic [3:0]        hex_val;
	logic [15:0]       acc_new;
	logic [15:0]       chr;

	assign chr      = {8'h00, text_byte};
	assign is_punct = text_byte inside {CH_COLON, CH_COMMA, CH_LBRACE, CH_RBRACE,
		CH_LBRACK, CH_RBRACK};
	assign is_space = text_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
	assign is_digit = text_byte inside {[8'h30:8'h39]};
	assign is_uhex  = text_byte inside {[8'h41:8'h46]};
	assign hex_val  = is_digit ? text_byte[3:0] : text_byte[3:0] + 4'd9;
	assign acc_new  = {acc_q[11:0], hex_val};

	always_comb begin
		mode_d    = mode_q;
		hex_cnt_d = hex_cnt_q;
		acc_d     = acc_q;
		bnd       = '0;
		if (end_of_text) begin
			if (mode_q == M_BARE) begin
				bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_END, 16'h0000,
					jtok_pkg::TYPE_BARE);
				bnd.res[1] = jtok_pkg::mk_result(jtok_pkg::KIND_DONE, 16'h0000,
					jtok_pkg::TYPE_BARE);
				bnd.count  = 2'd2;
			end else if (mode_q == M_STR || mode_q == M_ESC || mode_q == M_HEX) begin
				bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_ERROR, 16'h0000,
					jtok_pkg::TYPE_BARE);
				bnd.res[1] = jtok_pkg::mk_result(jtok_pkg::KIND_DONE, 16'h0000,
					jtok_pkg::TYPE_BARE);
				bnd.count  = 2'd2;
			end else begin
				bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_DONE, 16'h0000,
					jtok_pkg::TYPE_BARE);
				bnd.count  = 2'd1;
			end
			mode_d    = M_IDLE;
			hex_cnt_d = 2'd0;
			acc_d     = 16'h0000;
		end else begin
			case (mode_q)
				M_BARE: begin
					if (is_punct) begin
						bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_END, 16'h0000,
							jtok_pkg::TYPE_BARE);
						bnd.res[1] = jtok_pkg::mk_result(jtok_pkg::KIND_CHAR, chr,
							jtok_pkg::TYPE_PUNCT);
						bnd.res[2] = jtok_pkg::mk_result(jtok_pkg::KIND_END, 16'h0000,
							jtok_pkg::TYPE_PUNCT);
						bnd.count  = 2'd3;
						mode_d     = M_IDLE;
					end else if (text_byte == CH_QUOTE) begin
						mode_d = M_STR;
					end else begin
						bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_CHAR, chr,
							jtok_pkg::TYPE_BARE);
						bnd.count  = 2'd1;
					end
				end
				M_STR: begin
					if (text_byte == CH_BSLASH) begin
						mode_d = M_ESC;
					end else if (text_byte == CH_QUOTE) begin
						bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_END, 16'h0000,
							jtok_pkg::TYPE_STR);
						bnd.count  = 2'd1;
						mode_d     = M_IDLE;
					end else begin
						bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_CHAR, chr,
							jtok_pkg::TYPE_STR);
						bnd.count  = 2'd1;
					end
				end
				M_ESC: begin
					bnd.count  = 2'd1;
					mode_d     = M_STR;
					case (text_byte)
						CH_BSLASH, CH_SLASH, CH_QUOTE: begin
							bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_CHAR, chr,
								jtok_pkg::TYPE_STR);
						end
						CH_LOW_B: begin
							bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_CHAR,
								{8'h00, CH_BSLASH & 8'h00 | 8'h08}, jtok_pkg::TYPE_STR);
						end
						CH_LOW_N: begin
							bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_CHAR,
								{8'h00, CH_LF}, jtok_pkg::TYPE_STR);
						end
						CH_LOW_R: begin
							bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_CHAR,
								{8'h00, CH_CR}, jtok_pkg::TYPE_STR);
						end
						CH_LOW_T: begin
							bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_CHAR,
								{8'h00, CH_TAB}, jtok_pkg::TYPE_STR);
						end
						CH_LOW_U: begin
							bnd.count = 2'd0;
							mode_d    = M_HEX;
							hex_cnt_d = 2'd0;
							acc_d     = 16'h0000;
						end
						default: begin
							bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_ERROR, 16'h0000,
								jtok_pkg::TYPE_BARE);
							mode_d     = M_ERR;
							hex_cnt_d  = 2'd0;
							acc_d      = 16'h0000;
						end
					endcase
				end
				M_HEX: begin
					if (is_digit || is_uhex) begin
						if (hex_cnt_q == 2'd3) begin
							// Fourth digit: emit the whole accumulated code.
							bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_CHAR, acc_new,
								jtok_pkg::TYPE_STR);
							bnd.count  = 2'd1;
							mode_d     = M_STR;
							hex_cnt_d  = 2'd0;
							acc_d      = 16'h0000;
						end else begin
							hex_cnt_d = hex_cnt_q + 2'd1;
							acc_d     = acc_new;
						end
					end else begin
						bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_ERROR, 16'h0000,
							jtok_pkg::TYPE_BARE);
						bnd.count  = 2'd1;
						mode_d     = M_ERR;
						hex_cnt_d  = 2'd0;
						acc_d      = 16'h0000;
					end
				end
				M_ERR: begin
					mode_d = M_ERR;
				end
				default: begin
					if (is_space) begin
						mode_d = M_IDLE;
					end else if (is_punct) begin
						bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_CHAR, chr,
							jtok_pkg::TYPE_PUNCT);
						bnd.res[1] = jtok_pkg::mk_result(jtok_pkg::KIND_END, 16'h0000,
							jtok_pkg::TYPE_PUNCT);
						bnd.count  = 2'd2;
						mode_d     = M_IDLE;
					end else if (text_byte == CH_QUOTE) begin
						mode_d = M_STR;
					end else begin
						bnd.res[0] = jtok_pkg::mk_result(jtok_pkg::KIND_CHAR, chr,
							jtok_pkg::TYPE_BARE);
						bnd.count  = 2'd1;
						mode_d     = M_BARE;
					end
				end
			endcase
		end
	end

	assign text_stall = qstat.full;
	assign accept     = text_valid & ~qstat.full;
	assign push       = accept & (bnd.count != 2'd0);
	assign push_data  = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			hex_cnt_q <= 2'd0;
			acc_q     <= 16'h0000;
		end else if (accept) begin
			mode_q    <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			acc_q     <= acc_d;
		end
	end

endmodule

/* hdl/jtok_queue.sv */
// ----------------------------------------------------------------------------
// jtok_queue: result bundle queue
// A short first-in first-out queue of result bundles between the front end
// and the back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module jtok_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  jtok_pkg::bundle_t  push_data,
	input  logic               pop,
	output jtok_pkg::bundle_t  head,
	output jtok_pkg::qstat_t   qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	jtok_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              do_push, do_pop;

	assign qstat.full  = (cnt_q == FULL_CNT);
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push & ~qstat.full;
	assign do_pop      = pop & ~qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/jtok_back.sv */
// ----------------------------------------------------------------------------
// jtok_back: result serializer
// Takes the bundle at the head of the queue apart into single result items
// and drives them through the output register, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module jtok_back (
	input  logic               clk,
	input  logic               arst_n,
	input  jtok_pkg::qstat_t   qstat,
	input  jtok_pkg::bundle_t  head,
	output logic               pop,
	output logic               token_valid,
	input  logic               token_stall,
	output logic [1:0]         kind,
	output logic [15:0]        char_code,
	output logic [1:0]         token_type,
	output logic               last
);

	logic              valid_q;
	logic [1:0]        idx_q;
	jtok_pkg::result_t cur;
	jtok_pkg::result_t res_q;
	logic              last_q;
	logic              load, take, is_last;

	always_comb begin
		case (idx_q)
			2'd0:    cur = head.res[0];
			2'd1:    cur = head.res[1];
			default: cur = head.res[2];
		endcase
	end

	assign is_last = (idx_q == head.count - 2'd1);
	assign load    = ~valid_q | ~token_stall;
	assign take    = load & ~qstat.empty;
	assign pop     = take & is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (take) begin
			valid_q <= 1'b1;
			idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
		end else if (load) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q  <= cur;
			last_q <= is_last;
		end
	end

	assign token_valid = valid_q;
	assign kind        = res_q.kind;
	assign char_code   = res_q.code;
	assign token_type  = res_q.ttype;
	assign last        = last_q;

endmodule

/* hdl/json_tokenizer.sv */
// ----------------------------------------------------------------------------
// json_tokenizer: streaming JSON lexer
// Turns JSON text, one byte per item, into token characters and token-end,
// error and end-of-text marks, with string escapes decoded.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// text      in         text_valid / text_stall    text_byte, end_of_text
// token     out        token_valid / token_stall  kind, char_code, token_type, last
//
// The front end takes one text item per cycle whenever the result queue has
// room. Each item causes zero to three result items; the output register
// sends one result item per cycle while token_stall is low, so the sustained
// rate is one text item per cycle while items average at most one result,
// and the output port sets it otherwise. The first result item of a text
// item goes through the queue and the output register before it shows on
// the token ports. Reset clears the lexer state, the queue and the output valid.
// A stall on the token side fills the queue and then raises text_stall; a
// silent text side simply lets the queue drain.
module json_tokenizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	input  logic        text_valid,
	output logic        text_stall,
	output logic [1:0]  kind,
	output logic [15:0] char_code,
	output logic [1:0]  token_type,
	output logic        last,
	output logic        token_valid,
	input  logic        token_stall
);

	// Each queue entry holds every result of one text item, so the front end
	// waits on the token side only once QUEUE_DEPTH bundles fill the queue.
	jtok_pkg::bundle_t push_data, head;
	jtok_pkg::qstat_t  qstat;
	logic              push, pop;

	jtok_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.qstat      (qstat),
		.push       (push),
		.push_data  (push_data)
	);

	jtok_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// The back end walks through the head bundle and marks its final result.
	jtok_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head       (head),
		.pop        (pop),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.kind       (kind),
		.char_code  (char_code),
		.token_type (token_type),
		.last       (last)
	);

endmodule

/* hdl/jtok_checker.sv */
// ----------------------------------------------------------------------------
// jtok_checker: port checks for the JSON tokenizer
// Watches the top-level ports and flags result items that break the rules
// of the token channel.
// ----------------------------------------------------------------------------
module jtok_checker (
	input logic        clk,
	input logic        arst_n,
	input logic [1:0]  kind,
	input logic [15:0] char_code,
	input logic [1:0]  token_type,
	input logic        last,
	input logic        token_valid,
	input logic        token_stall
);

	// A stalled result item stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(kind) &&
		$stable(char_code) && $stable(token_type) && $stable(last))
		else $error("token item changed while stalled");

	// The end-of-text mark always closes the results of its text item.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && kind == jtok_pkg::KIND_DONE |-> last)
		else $error("end-of-text mark without last");

	// Only token characters carry a code.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && kind != jtok_pkg::KIND_CHAR |-> char_code == 16'h0000)
		else $error("nonzero code on a mark");

	// Error and end-of-text marks carry no token type.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (kind == jtok_pkg::KIND_ERROR || kind == jtok_pkg::KIND_DONE)
		|-> token_type == jtok_pkg::TYPE_BARE)
		else $error("token type on an error or end-of-text mark");

	// An error mark is either last or followed directly by the end-of-text mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_stall && kind == jtok_pkg::KIND_ERROR && !last
		|=> !token_valid || kind == jtok_pkg::KIND_DONE)
		else $error("error mark followed by something other than end of text");

endmodule

bind json_tokenizer jtok_checker u_jtok_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.kind       (kind),
	.char_code  (char_code),
	.token_type (token_type),
	.last       (last),
	.token_valid(token_valid),
	.token_stall(token_stall)
);

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking regression for the JSON tokenizer
// Feeds JSON text one byte per item, predicts every token character and every
// token-end, error and end-of-text mark with a behavioral lexer kept in this
// module, and checks each result item against the oldest prediction. Both
// channels idle and stall at random, with some stretches run flat out.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT  = 250000;
	localparam int RANDOM_ITEMS = 180;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;

	// Character pools for the random text, indexed one byte at a time.
	localparam logic [47:0]  PUNCT_CHARS  = ":,{}[]";
	localparam logic [31:0]  SPACE_CHARS  = {8'h20, 8'h09, 8'h0A, 8'h0D};
	localparam logic [55:0]  ESCAPE_CHARS = "\\/\"bnrt";
	localparam logic [127:0] HEX_CHARS    = "0123456789ABCDEF";

	// Lexer position as the testbench tracks it.
	typedef enum logic [5:0] {
		LX_BETWEEN = 6'b000001,
		LX_BARE    = 6'b000010,
		LX_STRING  = 6'b000100,
		LX_ESCAPE  = 6'b001000,
		LX_HEX     = 6'b010000,
		LX_DISCARD = 6'b100000
	} lex_state_t;

	// One result item as it is expected on the token channel.
	typedef struct {
		jtok_pkg::kind_t  kind;
		logic [15:0]      code;
		jtok_pkg::ttype_t ttype;
		logic             last;
	} lexeme_t;

	logic        clk;
	logic        arst_n;
	logic [7:0]  text_byte;
	logic        end_of_text;
	logic        text_valid;
	logic        text_stall;
	logic [1:0]  kind;
	logic [15:0] char_code;
	logic [1:0]  token_type;
	logic        last;
	logic        token_valid;
	logic        token_stall;

	// Predicted lexer state.
	lex_state_t  lex_state;
	logic [1:0]  hex_count;
	logic [15:0] hex_acc;

	lexeme_t     awaited_lexemes[$];

	// Bookkeeping for the summary and the verdict.
	int fails;
	int cycle_count;
	int items_sent;
	int meaningful_items;
	int texts_sent;
	int lexemes_checked;
	int predicted_errors;
	int drains;
	int stall_left;

	// When set, the matching side runs without idle cycles.
	bit send_calm;
	bit recv_calm;

	json_tokenizer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.kind        (kind),
		.char_code   (char_code),
		.token_type  (token_type),
		.last        (last),
		.token_valid (token_valid),
		.token_stall (token_stall)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Character classes and the lexer prediction.
	// ------------------------------------------------------------------------
	function automatic bit is_punct(logic [7:0] c);
		case (c)
			":", ",", "{", "}", "[", "]": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction

	// Value of an upper-case hex digit, or -1 for anything else.
	function automatic int hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c) - int'("0");
		if (c >= "A" && c <= "F")
			return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic void note(jtok_pkg::kind_t k, logic [15:0] code,
			jtok_pkg::ttype_t t);
		lexeme_t x;
		x.kind  = k;
		x.code  = code;
		x.ttype = t;
		x.last  = 1'b0;
		awaited_lexemes.push_back(x);
	endfunction

	// Errors and end-of-text marks carry a zero type field, which is TYPE_BARE.
	function automatic void raise_lex_error();
		note(jtok_pkg::KIND_ERROR, 16'h0000, jtok_pkg::TYPE_BARE);
		lex_state = LX_DISCARD;
		hex_count = 2'd0;
		hex_acc = 16'h0000;
		predicted_errors++;
	endfunction

	// Advances the predicted lexer by one text item and queues its results.
	function automatic void lex_byte(logic [7:0] c, logic eot);
		int          base;
		int          v;
		bit          plain_ok;
		logic [7:0]  plain;
		lexeme_t     tail;
		base = awaited_lexemes.size();
		if (eot) begin
			if (lex_state == LX_BARE)
				note(jtok_pkg::KIND_END, 16'h0000, jtok_pkg::TYPE_BARE);
			else if (lex_state == LX_STRING || lex_state == LX_ESCAPE || lex_state == LX_HEX)
				raise_lex_error();
			note(jtok_pkg::KIND_DONE, 16'h0000, jtok_pkg::TYPE_BARE);
			lex_state = LX_BETWEEN;
			hex_count = 2'd0;
			hex_acc = 16'h0000;
		end else begin
			case (lex_state)
				LX_BARE: begin
					// A bare word closes only at punctuation (or at end of text), and
					// the punctuation forms its own one-character token. A quote turns
					// the word into a string without taking back what was already sent.
					if (is_punct(c)) begin
						note(jtok_pkg::KIND_END, 16'h0000, jtok_pkg::TYPE_BARE);
						note(jtok_pkg::KIND_CHAR, {8'h00, c}, jtok_pkg::TYPE_PUNCT);
						note(jtok_pkg::KIND_END, 16'h0000, jtok_pkg::TYPE_PUNCT);
						lex_state = LX_BETWEEN;
					end else if (c == CH_QUOTE) begin
						lex_state = LX_STRING;
					end else begin
						note(jtok_pkg::KIND_CHAR, {8'h00, c}, jtok_pkg::TYPE_BARE);
					end
				end
				LX_STRING: begin
					if (c == CH_BSLASH) begin
						lex_state = LX_ESCAPE;
					end else if (c == CH_QUOTE) begin
						note(jtok_pkg::KIND_END, 16'h0000, jtok_pkg::TYPE_STR);
						lex_state = LX_BETWEEN;
					end else begin
						note(jtok_pkg::KIND_CHAR, {8'h00, c}, jtok_pkg::TYPE_STR);
					end
				end
				LX_ESCAPE: begin
					plain_ok = 1'b1;
					plain = c;
					case (c)
						CH_BSLASH, CH_SLASH, CH_QUOTE: plain = c;
						"b": plain = 8'h08;
						"n": plain = 8'h0A;
						"r": plain = 8'h0D;
						"t": plain = 8'h09;
						default: plain_ok = 1'b0;
					endcase
					if (c == "u") begin
						lex_state = LX_HEX;
						hex_count = 2'd0;
						hex_acc = 16'h0000;
					end else if (plain_ok) begin
						note(jtok_pkg::KIND_CHAR, {8'h00, plain}, jtok_pkg::TYPE_STR);
						lex_state = LX_STRING;
					end else begin
						raise_lex_error();
					end
				end
				LX_HEX: begin
					v = hex_nibble(c);
					if (v < 0) begin
						raise_lex_error();
					end else begin
						// The fourth digit releases the whole accumulated code.
						hex_acc = {hex_acc[11:0], v[3:0]};
						if (hex_count == 2'd3) begin
							note(jtok_pkg::KIND_CHAR, hex_acc, jtok_pkg::TYPE_STR);
							lex_state = LX_STRING;
							hex_count = 2'd0;
							hex_acc = 16'h0000;
						end else begin
							hex_count = hex_count + 2'd1;
						end
					end
				end
				LX_DISCARD: begin
					// Everything up to the end of the text is dropped.
				end
				default: begin
					if (is_space(c)) begin
						lex_state = LX_BETWEEN;
					end else if (is_punct(c)) begin
						note(jtok_pkg::KIND_CHAR, {8'h00, c}, jtok_pkg::TYPE_PUNCT);
						note(jtok_pkg::KIND_END, 16'h0000, jtok_pkg::TYPE_PUNCT);
						lex_state = LX_BETWEEN;
					end else if (c == CH_QUOTE) begin
						lex_state = LX_STRING;
					end else begin
						note(jtok_pkg::KIND_CHAR, {8'h00, c}, jtok_pkg::TYPE_BARE);
						lex_state = LX_BARE;
					end
				end
			endcase
		end
		// The final result of an item carries the last flag.
		if (awaited_lexemes.size() > base) begin
			tail = awaited_lexemes.pop_back();
			tail.last = 1'b1;
			awaited_lexemes.push_back(tail);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Text side: one item per call, with a random lead-in gap. Valid stays
	// high after acceptance so that back-to-back items see no bubble.
	// ------------------------------------------------------------------------
	task automatic send_text(input logic [7:0] b, input logic eot);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_byte <= b;
		end_of_text <= eot;
		text_valid <= 1'b1;
		@(posedge clk);
		while (text_stall)
			@(posedge clk);
		items_sent++;
		// Whitespace between tokens and bytes after an error do nothing.
		if (eot || !(lex_state == LX_DISCARD || (lex_state == LX_BETWEEN && is_space(b))))
			meaningful_items++;
		lex_byte(b, eot);
	endtask

	task automatic send_char(input logic [7:0] c);
		send_text(c, 1'b0);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// The byte that rides along with end of text is meaningless, so it is random.
	task automatic end_text();
		send_text(8'($urandom_range(0, 255)), 1'b1);
		texts_sent++;
	endtask

	// Hold the text side off until every predicted result has been seen.
	task automatic drain_wait();
		text_valid <= 1'b0;
		while (awaited_lexemes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		drains++;
	endtask

	// ------------------------------------------------------------------------
	// Token side: check every accepted result item, then draw a stall.
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string field, input logic [15:0] want,
			input logic [15:0] got);
		fails++;
		$error("%s: expected %0h, got %0h", field, want, got);
	endtask

	task automatic check_lexeme();
		lexeme_t want;
		if (awaited_lexemes.size() == 0) begin
			fails++;
			$error("unexpected result item: kind %0d char_code %0h", kind, char_code);
		end else begin
			want = awaited_lexemes.pop_front();
			if (kind !== want.kind)
				report_mismatch("kind", want.kind, kind);
			if (char_code !== want.code)
				report_mismatch("char_code", want.code, char_code);
			if (token_type !== want.ttype)
				report_mismatch("token_type", want.ttype, token_type);
			if (last !== want.last)
				report_mismatch("last", want.last, last);
			lexemes_checked++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall) begin
			check_lexeme();
			stall_left = recv_calm ? 0 : $urandom_range(0, 12);
		end else if (stall_left > 0) begin
			stall_left--;
		end else if (!recv_calm && !token_valid && $urandom_range(0, 15) == 0) begin
			// An occasional stall raised while the channel is quiet, so that
			// the first result of a burst meets one too.
			stall_left = $urandom_range(1, 12);
		end
		token_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results still awaited",
				cycle_count, awaited_lexemes.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Directed tests.
	// ------------------------------------------------------------------------

	// Bare words: a skipped leading space, byte zero and 0xFF as ordinary
	// characters, trailing whitespace kept, closing at punctuation and at
	// end of text.
	task automatic test_bare_words();
		send_char(8'h20);
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h09);
		send_char("}");
		send_str("ab");
		end_text();
	endtask

	// Strings: the empty string, a quote that turns a bare word into a
	// string, and the largest and smallest four-digit codes.
	task automatic test_strings();
		send_str("\"\"");
		send_str("x\"\\uFFFF\\u0000\"");
		end_text();
	endtask

	// Broken text: an unknown escape with discarded bytes after it, a
	// non-hex character inside a code, and end of text right after a backslash.
	task automatic test_broken_escapes();
		send_str("\"\\q");
		send_char("a");
		end_text();
		send_str("\"\\u1g");
		end_text();
		send_str("\"\\");
		end_text();
	endtask

	// ------------------------------------------------------------------------
	// Random texts: mostly well-formed tokens with random content, some
	// noise bytes, and now and then a broken tail.
	// ------------------------------------------------------------------------
	task automatic random_string();
		logic [7:0] c;
		send_char(CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 3))
				0: begin
					send_char(CH_BSLASH);
					send_char(ESCAPE_CHARS[8*$urandom_range(0, 6) +: 8]);
				end
				1: begin
					send_char(CH_BSLASH);
					send_char("u");
					repeat (4) send_char(HEX_CHARS[8*$urandom_range(0, 15) +: 8]);
				end
				default: begin
					do c = 8'($urandom_range(0, 255));
					while (c == CH_QUOTE || c == CH_BSLASH);
					send_char(c);
				end
			endcase
		end
		send_char(CH_QUOTE);
	endtask

	task automatic random_bare();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (is_punct(c) || is_space(c) || c == CH_QUOTE);
		send_char(c);
		repeat ($urandom_range(0, 5)) begin
			do c = 8'($urandom_range(0, 255));
			while (is_punct(c) || c == CH_QUOTE);
			send_char(c);
		end
	endtask

	task automatic random_token();
		case ($urandom_range(0, 9))
			0, 1, 2: send_char(PUNCT_CHARS[8*$urandom_range(0, 5) +: 8]);
			3: repeat ($urandom_range(1, 3)) send_char(SPACE_CHARS[8*$urandom_range(0, 3) +: 8]);
			4, 5: random_bare();
			6, 7, 8: random_string();
			default: send_char(8'($urandom_range(0, 255)));
		endcase
	endtask

	// Ends a text inside a string in one of the ways that must be reported.
	task automatic broken_tail();
		logic [7:0] c;
		int         shape;
		shape = $urandom_range(0, 4);
		send_char(CH_QUOTE);
		case (shape)
			0: begin
				send_char(CH_BSLASH);
				do c = 8'($urandom_range(0, 255));
				while (c == CH_BSLASH || c == CH_SLASH || c == CH_QUOTE || c == "b" ||
					c == "n" || c == "r" || c == "t" || c == "u");
				send_char(c);
			end
			1: begin
				send_str("\\u");
				repeat ($urandom_range(0, 3)) send_char(HEX_CHARS[8*$urandom_range(0, 15) +: 8]);
				do c = 8'($urandom_range(0, 255));
				while (hex_nibble(c) >= 0);
				send_char(c);
			end
			2: repeat ($urandom_range(0, 3)) send_char(8'("a" + $urandom_range(0, 25)));
			3: send_char(CH_BSLASH);
			default: begin
				send_str("\\u");
				repeat ($urandom_range(0, 3)) send_char(HEX_CHARS[8*$urandom_range(0, 15) +: 8]);
			end
		endcase
		// After a reported error the lexer should swallow anything.
		if (shape <= 1)
			repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(0, 255)));
	endtask

	task automatic test_random_texts();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			send_calm = ($urandom_range(0, 3) == 0);
			recv_calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 8)) random_token();
			if ($urandom_range(0, 3) == 0)
				broken_tail();
			end_text();
			if ($urandom_range(0, 7) == 0)
				drain_wait();
		end
		send_calm = 1'b0;
		recv_calm = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Sequence of the run.
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		text_byte = 8'h00;
		end_of_text = 1'b0;
		text_valid = 1'b0;
		token_stall = 1'b0;
		stall_left = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		lex_state = LX_BETWEEN;
		hex_count = 2'd0;
		hex_acc = 16'h0000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bare_words();
		test_strings();
		test_broken_escapes();
		// The sender waits here for the block to run completely dry.
		drain_wait();
		test_random_texts();

		drain_wait();
		repeat (8) @(posedge clk);

		$display("Sent %0d text items in %0d texts (%0d that do work), checked %0d results.",
			items_sent, texts_sent, meaningful_items, lexemes_checked);
		$display("Covered %0d lexer errors and %0d full drains of the result path.",
			predicted_errors, drains);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
